/* sv/tst_pkg.sv */
// Package for the topic subscription table: sizes, command and status codes,
// and the sequencer state type. No dependencies.
package tst_pkg;

  localparam int unsigned TopicSlotsDef   = 16;
  localparam int unsigned SubsPerTopicDef = 16;
  localparam int unsigned ClientLimitDef  = 1024;
  localparam int unsigned KeyBytesDef     = 8;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned KeyW    = 64;
  localparam int unsigned ClientW = 10;
  localparam int unsigned TagW    = 16;
  localparam int unsigned StatusW = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_SUB   = 2'd0,
    CMD_UNSUB = 2'd1,
    CMD_PUB   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_DELIVER      = 3'd0,
    ST_SUBSCRIBED   = 3'd1,
    ST_ALREADY      = 3'd2,
    ST_REMOVED      = 3'd3,
    ST_NOT_LISTED   = 3'd4,
    ST_TOPICS_FULL  = 3'd5,
    ST_LIST_FULL    = 3'd6,
    ST_NO_RECEIVERS = 3'd7
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_KEY_RD,
    S_KEY_CMP,
    S_CNT_RD,
    S_CNT_USE,
    S_ID_RD,
    S_ID_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_APPEND,
    S_PUB_RD,
    S_PUB_OUT,
    S_RESULT
  } state_e;

endpackage

/* sv/tst_if.sv */
// Channel interfaces for the topic subscription table: request and result words
// with valid/ready. Depends on tst_pkg.
interface tst_req_if import tst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CmdW-1:0]    cmd;
  logic [KeyW-1:0]    topic_key;
  logic [ClientW-1:0] client_id;
  logic [TagW-1:0]    message_tag;
  modport source (output valid, cmd, topic_key, client_id, message_tag, input ready);
  modport sink   (input valid, cmd, topic_key, client_id, message_tag, output ready);
endinterface

interface tst_rsp_if import tst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [ClientW-1:0] dest_client;
  logic [TagW-1:0]    out_tag;
  logic               last;
  modport source (output valid, status, dest_client, out_tag, last, input ready);
  modport sink   (input valid, status, dest_client, out_tag, last, output ready);
endinterface

/* sv/topic_subscription_table.sv */
// Topic subscription table top level: memories for keys, counts and ids,
// and the scan sequencer. Depends on tst_pkg and the channel interfaces.
//
// Usage: requests arrive on req_i (cmd, topic_key, client_id, message_tag);
// results leave on rsp_o (status, dest_client, out_tag, last). A word moves
// when valid and ready are both high. One request is worked on at a time.
// The sequencer scans the key memory one entry at a time, then the
// subscriber list one entry at a time, since every memory read is
// registered before the compare. An unsubscribe shifts each later entry
// down one place, read and then written; a publish gives one word per
// subscriber, each read and then sent, and waits while the receiver stalls.
// Results sit in an output register; when the receiver stalls, the sequencer
// waits on that register and nothing is lost. A request with code 3 gives no
// result. Reset clears the topic count and the sequencer; the memories keep
// their contents and are only read where written, so no clearing pass runs.
module topic_subscription_table import tst_pkg::*; #(
  parameter int unsigned TOPIC_SLOTS    = TopicSlotsDef,
  parameter int unsigned SUBS_PER_TOPIC = SubsPerTopicDef,
  parameter int unsigned CLIENT_LIMIT   = ClientLimitDef,
  parameter int unsigned KEY_BYTES      = KeyBytesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tst_req_if.sink      req_i,
  tst_rsp_if.source    rsp_o
);

  localparam int unsigned SlotW  = (TOPIC_SLOTS > 1) ? $clog2(TOPIC_SLOTS) : 1;
  localparam int unsigned UsedW  = $clog2(TOPIC_SLOTS + 1);
  localparam int unsigned CntW   = $clog2(SUBS_PER_TOPIC + 1);
  localparam int unsigned IdDep  = TOPIC_SLOTS * SUBS_PER_TOPIC;
  localparam int unsigned IdAddrW = (IdDep > 1) ? $clog2(IdDep) : 1;
  localparam logic [KeyW-1:0] KeyMask =
    (KEY_BYTES >= 8) ? {KeyW{1'b1}} : ((KeyW'(1) << (8 * KEY_BYTES)) - KeyW'(1));
  localparam logic [ClientW:0] ClientLim =
    (CLIENT_LIMIT > 1024) ? (ClientW+1)'(1024) : (ClientW+1)'(CLIENT_LIMIT);

  // Memories.
  logic [KeyW-1:0]    key_mem [TOPIC_SLOTS];
  logic [CntW-1:0]    cnt_mem [TOPIC_SLOTS];
  logic [ClientW-1:0] id_mem  [IdDep];
  logic [KeyW-1:0]    key_rd;
  logic [CntW-1:0]    cnt_rd;
  logic [ClientW-1:0] id_rd;

  state_e state_q, state_d;
  logic [UsedW-1:0]   used_q, used_d;
  logic [UsedW-1:0]   tidx_q, tidx_d;
  logic [CntW-1:0]    pos_q, pos_d;
  logic [CntW-1:0]    n_q, n_d;
  logic               found_q, found_d;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic [ClientW-1:0] shift_q, shift_d;
  cmd_e               cmd_q;
  logic [KeyW-1:0]    key_q;
  logic [ClientW-1:0] client_q;
  logic [TagW-1:0]    tag_q;
  logic               client_ok_q;

  // Output register.
  logic               ov_q, ov_d;
  logic [StatusW-1:0] ost_q, ost_d;
  logic [ClientW-1:0] odst_q, odst_d;
  logic [TagW-1:0]    otag_q, otag_d;
  logic               olast_q, olast_d;

  // Memory controls.
  logic               key_we, cnt_we, id_we;
  logic [SlotW-1:0]   key_ra, cnt_a;
  logic [IdAddrW-1:0] id_ra, id_wa;
  logic [ClientW-1:0] id_wd;
  logic [CntW-1:0]    cnt_wd;

  logic out_free;
  logic accept;

  assign out_free = !ov_q || rsp_o.ready;
  assign accept   = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  function automatic logic [IdAddrW-1:0] id_addr(logic [SlotW-1:0] s, logic [CntW-1:0] p);
    logic [IdAddrW+CntW:0] a;
    a = (IdAddrW+CntW+1)'(s) * (IdAddrW+CntW+1)'(SUBS_PER_TOPIC) + (IdAddrW+CntW+1)'(p);
    return a[IdAddrW-1:0];
  endfunction

  // A new topic takes the slot at the current topic count.
  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[used_q[SlotW-1:0]] <= key_q;
    key_rd <= key_mem[key_ra];
    if (cnt_we) cnt_mem[cnt_a] <= cnt_wd;
    cnt_rd <= cnt_mem[cnt_a];
    if (id_we) id_mem[id_wa] <= id_wd;
    id_rd <= id_mem[id_ra];
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q       <= cmd_e'(req_i.cmd);
      key_q       <= req_i.topic_key & KeyMask;
      client_q    <= req_i.client_id;
      tag_q       <= req_i.message_tag;
      client_ok_q <= ({1'b0, req_i.client_id} < ClientLim);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    used_d  = used_q;
    tidx_d  = tidx_q;
    pos_d   = pos_q;
    n_d     = n_q;
    found_d = found_q;
    slot_d  = slot_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          tidx_d  = '0;
          found_d = 1'b0;
          state_d = (cmd_e'(req_i.cmd) == CMD_NONE) ? S_IDLE : S_KEY_RD;
        end
      end
      S_KEY_RD: begin
        if (tidx_q >= used_q) begin
          state_d = S_CNT_RD;
        end else begin
          state_d = S_KEY_CMP;
        end
      end
      S_KEY_CMP: begin
        if (key_rd == key_q) begin
          found_d = 1'b1;
          slot_d  = tidx_q[SlotW-1:0];
          state_d = S_CNT_RD;
        end else begin
          tidx_d  = tidx_q + UsedW'(1);
          state_d = S_KEY_RD;
        end
      end
      S_CNT_RD: begin
        // From here on found tells whether the client is listed.
        state_d = S_RESULT;
        found_d = 1'b0;
        if (cmd_q == CMD_SUB && client_ok_q) begin
          if (found_q) begin
            state_d = S_CNT_USE;
          end else if (used_q < UsedW'(TOPIC_SLOTS)) begin
            slot_d  = used_q[SlotW-1:0];
            used_d  = used_q + UsedW'(1);
            n_d     = '0;
            state_d = S_APPEND;
          end
        end else if (found_q && (cmd_q == CMD_PUB || client_ok_q)) begin
          state_d = S_CNT_USE;
        end
      end
      S_CNT_USE: begin
        n_d   = cnt_rd;
        pos_d = '0;
        if (cmd_q == CMD_PUB) begin
          state_d = (cnt_rd == '0) ? S_RESULT : S_PUB_RD;
        end else begin
          state_d = S_ID_RD;
        end
      end
      S_ID_RD: begin
        if (pos_q >= n_q) begin
          state_d = (cmd_q == CMD_SUB && n_q < CntW'(SUBS_PER_TOPIC)) ? S_APPEND : S_RESULT;
        end else begin
          state_d = S_ID_CMP;
        end
      end
      S_ID_CMP: begin
        if (id_rd == client_q) begin
          if (cmd_q == CMD_SUB) begin
            state_d = S_RESULT;
          end else begin
            pos_d   = pos_q + CntW'(1);
            state_d = S_SHIFT_RD;
          end
          found_d = 1'b1;
        end else begin
          found_d = 1'b0;
          pos_d   = pos_q + CntW'(1);
          state_d = S_ID_RD;
        end
      end
      S_SHIFT_RD: begin
        // pos_q points at the entry that moves down one place.
        state_d = (pos_q >= n_q) ? S_RESULT : S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        pos_d   = pos_q + CntW'(1);
        state_d = S_SHIFT_RD;
      end
      S_APPEND: begin
        found_d = 1'b0;
        state_d = S_RESULT;
      end
      S_PUB_RD: begin
        state_d = S_PUB_OUT;
      end
      S_PUB_OUT: begin
        if (out_free) begin
          pos_d   = pos_q + CntW'(1);
          state_d = (pos_q + CntW'(1) >= n_q) ? S_IDLE : S_PUB_RD;
        end
      end
      S_RESULT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory and output controls.
  always_comb begin
    key_we = 1'b0;
    cnt_we = 1'b0;
    id_we  = 1'b0;
    key_ra = tidx_q[SlotW-1:0];
    cnt_a  = slot_q;
    cnt_wd = n_q;
    id_ra  = id_addr(slot_q, pos_q);
    id_wa  = id_addr(slot_q, n_q);
    id_wd  = client_q;
    ov_d   = ov_q && !rsp_o.ready;
    ost_d  = ost_q;
    odst_d = odst_q;
    otag_d = otag_q;
    olast_d = olast_q;
    shift_d = shift_q;
    unique case (state_q)
      S_CNT_RD: begin
        // Reads the count of the located slot for the next state, or writes the key of a new topic.
        if (state_d == S_APPEND) key_we = 1'b1;
        if (state_d == S_APPEND) begin
          cnt_a = used_q[SlotW-1:0];
        end
      end
      S_SHIFT_WR: begin
        id_we = 1'b1;
        id_wa = id_addr(slot_q, pos_q - CntW'(1));
        id_wd = id_rd;
      end
      S_SHIFT_RD: begin
        if (pos_q >= n_q) begin
          cnt_we = 1'b1;
          cnt_wd = n_q - CntW'(1);
        end
      end
      S_APPEND: begin
        id_we  = 1'b1;
        cnt_we = 1'b1;
        cnt_wd = n_q + CntW'(1);
      end
      S_PUB_OUT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ost_d   = ST_DELIVER;
          odst_d  = id_rd;
          otag_d  = tag_q;
          olast_d = (pos_q + CntW'(1) >= n_q);
        end
      end
      S_RESULT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          odst_d  = client_q;
          otag_d  = '0;
          olast_d = 1'b1;
          case (cmd_q)
            CMD_SUB: begin
              if (!client_ok_q) ost_d = ST_LIST_FULL;
              else ost_d = shift_q[StatusW-1:0];
            end
            CMD_UNSUB: ost_d = found_q ? ST_REMOVED : ST_NOT_LISTED;
            default: begin
              ost_d  = ST_NO_RECEIVERS;
              otag_d = tag_q;
            end
          endcase
        end
      end
      default: ;
    endcase
    // The subscribe outcome is decided on the way into the result state.
    if (state_q != S_RESULT && state_d == S_RESULT && cmd_q == CMD_SUB) begin
      if (state_q == S_APPEND) shift_d = ClientW'(ST_SUBSCRIBED);
      else if (state_q == S_ID_CMP) shift_d = ClientW'(ST_ALREADY);
      else if (state_q == S_ID_RD) shift_d = ClientW'(ST_LIST_FULL);
      else shift_d = ClientW'(ST_TOPICS_FULL);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tidx_q  <= tidx_d;
    pos_q   <= pos_d;
    n_q     <= n_d;
    found_q <= found_d;
    slot_q  <= slot_d;
    shift_q <= shift_d;
    ost_q   <= ost_d;
    odst_q  <= odst_d;
    otag_q  <= otag_d;
    olast_q <= olast_d;
  end

  assign rsp_o.valid       = ov_q;
  assign rsp_o.status      = ost_q;
  assign rsp_o.dest_client = odst_q;
  assign rsp_o.out_tag     = otag_q;
  assign rsp_o.last        = olast_q;

`ifndef ASSERT_OFF
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UsedW'(TOPIC_SLOTS)) else $error("topic count beyond table size");
  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q != $past(used_q) |-> used_q == $past(used_q) + UsedW'(1))
    else $error("topic count moved by more than one");
  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !req_i.ready) else $error("request taken while busy");
`endif

endmodule
